// File: hdl/audio_ring_gain_fifo_defines.svh
// Assertion macros used by the checker file.
`ifndef AUDIO_RING_GAIN_FIFO_DEFINES_SVH
`define AUDIO_RING_GAIN_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ARGF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ARGF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/argf_pkg.sv
// Package: sizes, register indexes, config struct and sample scaling for the ring FIFO.
package argf_pkg;

	// ring depth in samples; power of two so the counts wrap naturally
	localparam int RING_DEPTH = 16384;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int CNT_W      = RING_AW + 1;
	localparam int BANK_DEPTH = RING_DEPTH / 2;
	localparam int BANK_AW    = RING_AW - 1;
	localparam int SUM_W      = CNT_W + 2;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 10;
	localparam int FRAMES_W = 14;
	localparam int FILL_W   = 15;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(256);
	localparam logic [FRAMES_W-1:0] TARGET_RESET = FRAMES_W'(1536);

	typedef enum logic [1:0] {
		REG_ENABLED       = 2'd0,
		REG_GAIN_Q8       = 2'd1,
		REG_TARGET_FRAMES = 2'd2
	} argf_reg_t;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_PULL = 1'b1;

	typedef struct packed {
		logic                enabled;
		logic [GAIN_W-1:0]   gain_q8;
		logic [FRAMES_W-1:0] target_frames;
	} argf_cfg_t;

	// sample * gain, floor shift by 8, clamp to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] argf_scale(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [GAIN_W-1:0]          g
	);
		logic signed [SAMPLE_W+GAIN_W:0]   p;
		logic signed [SAMPLE_W+GAIN_W-8:0] q;
		logic signed [SAMPLE_W-1:0]        r;
		p = s * $signed({1'b0, g});
		q = p[SAMPLE_W+GAIN_W:8];
		if (q > $signed((SAMPLE_W+GAIN_W-7)'(32767))) begin
			r = 16'sh7FFF;
		end else if (q < -$signed((SAMPLE_W+GAIN_W-7)'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = q[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/argf_if.sv
// Item channels: push/pull requests in, results out.
interface argf_req_if;
	import argf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic                       first_of_chunk;
	logic [FRAMES_W-1:0]        chunk_frames;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;

	modport source (output valid, action, first_of_chunk, chunk_frames, left_in, right_in,
		input ready);
	modport sink (input valid, action, first_of_chunk, chunk_frames, left_in, right_in,
		output ready);
endinterface

interface argf_rsp_if;
	import argf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       underrun;
	logic [FILL_W-1:0]          fill_samples;

	modport source (output valid, accepted, sample_out, underrun, fill_samples,
		input ready);
	modport sink (input valid, accepted, sample_out, underrun, fill_samples,
		output ready);
endinterface

// File: hdl/argf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module argf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hdl/argf_cfg.sv
// APB-style register file: enabled, gain_q8, target_frames.
module argf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [argf_pkg::ADDR_W-1:0] paddr,
	input  logic [argf_pkg::DATA_W-1:0] pwdata,
	output logic [argf_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output argf_pkg::argf_cfg_t        cfg
);
	import argf_pkg::*;

	argf_cfg_t cfg_q;
	argf_reg_t reg_sel;
	logic      wr_en;

	assign reg_sel = argf_reg_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b0;
			cfg_q.gain_q8       <= GAIN_RESET;
			cfg_q.target_frames <= TARGET_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ENABLED:       cfg_q.enabled       <= pwdata[0];
				REG_GAIN_Q8:       cfg_q.gain_q8       <= pwdata[GAIN_W-1:0];
				REG_TARGET_FRAMES: cfg_q.target_frames <= pwdata[FRAMES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_ENABLED:       prdata = DATA_W'(cfg_q.enabled);
			REG_GAIN_Q8:       prdata = DATA_W'(cfg_q.gain_q8);
			REG_TARGET_FRAMES: prdata = DATA_W'(cfg_q.target_frames);
			default:           prdata = '0;
		endcase
	end
endmodule

// File: hdl/audio_ring_gain_fifo.sv
// Top level: stereo sample ring FIFO with chunk admission and Q8 gain.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  req     | in  | req.valid/req.ready  | action, first_of_chunk, chunk_frames, L, R
//  rsp     | out | rsp.valid/rsp.ready  | accepted, sample_out, underrun, fill_samples
//  apb     | in  | psel/penable/pready  | paddr, pwdata, prdata (enabled, gain, target)
//
// One item per cycle sustained while rsp is not stalled; a result passes s1 (decides),
// s2 (waits for the bank read) and then the output register before it is on rsp.
// Rate is set by the ring banks: a push writes one sample into each bank, a pull reads
// both banks and keeps one; one write and one read port per bank suffice for every item.
// Reset (arst_n low) empties the FIFO and clears the chunk flag; the ring has no clear.
// When rsp stalls, the whole pipe holds and req.ready drops in the same cycle.

module audio_ring_gain_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [argf_pkg::ADDR_W-1:0] paddr,
	input  logic [argf_pkg::DATA_W-1:0] pwdata,
	output logic [argf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	argf_req_if.sink                    req,
	argf_rsp_if.source                  rsp
);
	import argf_pkg::*;

	argf_cfg_t cfg;

	argf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// pipe advances whenever the output register is empty or being drained
	logic adv;
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// ---- stage 1: item captured, decided against the counters ----
	logic                       valid_s1;
	logic                       action_s1;
	logic                       first_s1;
	logic [FRAMES_W-1:0]        frames_s1;
	logic signed [SAMPLE_W-1:0] left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req.valid) begin
			action_s1 <= req.action;
			first_s1  <= req.first_of_chunk;
			frames_s1 <= req.chunk_frames;
			left_s1   <= req.left_in;
			right_s1  <= req.right_in;
		end
	end

	// counts run modulo twice the depth: fill is their difference, slot is the low bits
	logic [CNT_W-1:0] wr_cnt_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             chunk_ok_q;

	logic [CNT_W-1:0] fill_cur;
	logic [SUM_W-1:0] limit;
	logic [SUM_W-1:0] need;
	logic             admit;
	logic             adm_now;
	logic             room;
	logic             is_push;
	logic             is_pull;
	logic             store;
	logic             hit;
	logic [CNT_W-1:0] wr_cnt_nx;
	logic [CNT_W-1:0] rd_cnt_nx;
	logic [CNT_W-1:0] fill_nx;
	logic             acc_s1;

	always_comb begin
		fill_cur = wr_cnt_q - rd_cnt_q;
		// admission limit 2*target, saturated at the ring size
		limit = SUM_W'({cfg.target_frames, 1'b0});
		if (limit > SUM_W'(RING_DEPTH)) begin
			limit = SUM_W'(RING_DEPTH);
		end
		need    = SUM_W'(fill_cur) + SUM_W'({frames_s1, 1'b0});
		admit   = (frames_s1 == '0) || (need <= limit);
		adm_now = first_s1 ? admit : chunk_ok_q;
		room    = (SUM_W'(fill_cur) + SUM_W'(2)) <= SUM_W'(RING_DEPTH);
		is_push = valid_s1 && (action_s1 == ACT_PUSH);
		is_pull = valid_s1 && (action_s1 == ACT_PULL);
		// frame that does not fit is dropped silently, admission still reported
		store   = is_push && cfg.enabled && adm_now && room;
		hit     = is_pull && (fill_cur != '0);
		wr_cnt_nx = store ? wr_cnt_q + CNT_W'(2) : wr_cnt_q;
		rd_cnt_nx = hit ? rd_cnt_q + CNT_W'(1) : rd_cnt_q;
		fill_nx   = wr_cnt_nx - rd_cnt_nx;
		// disabled pushes are swallowed but report accepted
		acc_s1    = is_push && (!cfg.enabled || adm_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q   <= '0;
			rd_cnt_q   <= '0;
			chunk_ok_q <= 1'b0;
		end else if (adv) begin
			wr_cnt_q <= wr_cnt_nx;
			rd_cnt_q <= rd_cnt_nx;
			if (is_push && cfg.enabled && first_s1) begin
				chunk_ok_q <= admit;
			end
		end
	end

	// ---- ring: two banks, left samples on even slots, right on odd ----
	// write count only moves by two, so a frame always lands on one row of both banks
	logic [SAMPLE_W-1:0] rdata_l;
	logic [SAMPLE_W-1:0] rdata_r;
	logic [BANK_AW-1:0]  waddr;
	logic [BANK_AW-1:0]  raddr;
	logic                ram_we;
	logic                ram_re;

	assign waddr  = wr_cnt_q[RING_AW-1:1];
	assign raddr  = rd_cnt_q[RING_AW-1:1];
	assign ram_we = adv && store;
	assign ram_re = adv && hit;

	argf_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_bank_l (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(argf_scale(left_s1, cfg.gain_q8)),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata_l)
	);

	argf_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_bank_r (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(argf_scale(right_s1, cfg.gain_q8)),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata_r)
	);

	// ---- stage 2: waits for the bank read ----
	logic              valid_s2;
	logic              acc_s2;
	logic              under_s2;
	logic              hit_s2;
	logic              odd_s2;
	logic [CNT_W-1:0]  fill_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			acc_s2   <= acc_s1;
			under_s2 <= is_pull && !hit;
			hit_s2   <= hit;
			odd_s2   <= rd_cnt_q[0];
			fill_s2  <= fill_nx;
		end
	end

	// ---- output register ----
	logic                       out_valid_q;
	logic                       out_acc_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_under_q;
	logic [FILL_W-1:0]          out_fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			out_acc_q    <= acc_s2;
			out_under_q  <= under_s2;
			out_fill_q   <= FILL_W'(fill_s2);
			if (hit_s2) begin
				out_sample_q <= odd_s2 ? rdata_r : rdata_l;
			end else begin
				out_sample_q <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.accepted     = out_acc_q;
	assign rsp.sample_out   = out_sample_q;
	assign rsp.underrun     = out_under_q;
	assign rsp.fill_samples = out_fill_q;

endmodule

// File: hdl/argf_checker.sv
// Port-level checker for the ring FIFO, bound to the top level.
`include "audio_ring_gain_fifo_defines.svh"

module argf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_accepted,
	input logic [argf_pkg::SAMPLE_W-1:0] rsp_sample_out,
	input logic                          rsp_underrun,
	input logic [argf_pkg::FILL_W-1:0]   rsp_fill_samples
);
	import argf_pkg::*;

	`ARGF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`ARGF_ASSERT_SAME(a_ready_only_on_stall, !req_ready, rsp_valid && !rsp_ready, "input stalled without output stall")
	`ARGF_ASSERT_SAME(a_underrun_silent, rsp_valid && rsp_underrun, (rsp_sample_out == '0) && (rsp_fill_samples == '0) && !rsp_accepted, "underrun result malformed")
	`ARGF_ASSERT_SAME(a_fill_bound, rsp_valid, rsp_fill_samples <= FILL_W'(RING_DEPTH), "fill beyond ring size")

endmodule

bind audio_ring_gain_fifo argf_checker u_argf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_accepted    (rsp.accepted),
	.rsp_sample_out  (rsp.sample_out),
	.rsp_underrun    (rsp.underrun),
	.rsp_fill_samples(rsp.fill_samples)
);
